>>> hw/rtl/timeslice_task_scheduler_macros.svh
// Assertion macros used by the scheduler engine (tss_engine).
`ifndef TIMESLICE_TASK_SCHEDULER_MACROS_SVH
`define TIMESLICE_TASK_SCHEDULER_MACROS_SVH

// Clocked check, masked while reset is high.
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold.
`define TSS_ASSERT_NEVER(lbl, cond, msg) \
  `TSS_ASSERT(lbl, !(cond), msg)

`endif

>>> hw/rtl/tss_pkg.sv
// Types and constants for the timeslice task scheduler.
package tss_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int IDLE_SLOT_DEF = 0;

  // wide enough for any slot index and for the idle slot number
  localparam int CUR_W   = 8;
  localparam int SLICE_W = 8;
  localparam int RS_W    = 2;
  localparam int SEL_W   = 4;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [RS_W-1:0] RS_RUN   = 2'd0;
  localparam logic [RS_W-1:0] RS_INTR  = 2'd1;
  localparam logic [RS_W-1:0] RS_UNINT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_INC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_MAX = 8'd1;

  localparam logic [SLICE_W-1:0] SLICE_INC_RST = 8'd8;
  localparam logic [SLICE_W-1:0] SLICE_MAX_RST = 8'd64;

  typedef enum logic [1:0] {
    FN_SCHED = 2'd0,
    FN_WRITE = 2'd1,
    FN_WAKE  = 2'd2,
    FN_SLEEP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ONE,
    ST_WAKE,
    ST_SLEEP,
    ST_SCAN1,
    ST_SCAN2,
    ST_RESP
  } seq_state_t;

  typedef struct packed {
    logic               live;
    logic [RS_W-1:0]    run_state;
    logic [SLICE_W-1:0] slice;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    func_t              func;
    logic [SEL_W-1:0]   slot;
    logic               valid_in;
    logic [RS_W-1:0]    run_state_in;
    logic [SLICE_W-1:0] slice_in;
    logic               interruptible;
  } cmd_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice_inc;
    logic [SLICE_W-1:0] slice_max;
  } cfg_t;

  typedef struct packed {
    logic [SEL_W-1:0] chosen_slot;
    logic             switched;
    logic             error;
  } res_t;

endpackage

>>> hw/rtl/timeslice_task_scheduler.sv
// Timeslice task scheduler: top level with stream ports, config registers, output word.
//
// Input words arrive on s_tvalid/s_tready; s_tuser carries the request kind
// (schedule, write slot, wake slot, sleep current then schedule) and s_tdata
// the slot, live bit, run state, timeslice and sleep kind. Each input word
// gives exactly one output word on m_tvalid/m_tready with the current slot,
// the switch flag and the wake error flag.
// One request is processed at a time by a sequencer around a single slot
// RAM (one write and one registered read port per cycle). A write goes
// through its write state; a wake reads the slot, then writes it; a schedule
// scans every slot and, if no runnable slot has timeslice left, runs the
// refill pass; a sleep marks the current slot first. Each scan reads one slot per cycle.
// The next word is accepted in the cycle after the result is loaded,
// even while that result still waits in the output register; a stalled
// receiver holds the sequencer in its final state.
// Config writes (index 0 increment, 1 maximum) are ready whenever rst is low.
// Reset (rst, synchronous) makes only the idle slot live, all slots
// runnable with zero timeslice, and the idle slot current; no clearing pass.
module timeslice_task_scheduler
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int IDLE_SLOT = IDLE_SLOT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [3:0] slot, [4] valid_in, [6:5] run_state_in, [14:7] slice_in, [15] interruptible
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [3:0] chosen_slot, [4] switched, [5] error, [7:6] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SLICE_W-1:0]    cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  res_t out_q;
  logic res_valid, res_ready;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice_inc <= SLICE_INC_RST;
      cfg.slice_max <= SLICE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLICE_INC: cfg.slice_inc <= cfg_data;
        REG_SLICE_MAX: cfg.slice_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.func          = func_t'(s_tuser);
    cmd.slot          = s_tdata[3:0];
    cmd.valid_in      = s_tdata[4];
    cmd.run_state_in  = s_tdata[6:5];
    cmd.slice_in      = s_tdata[14:7];
    cmd.interruptible = s_tdata[15];
  end

  tss_engine #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDLE_SLOT(IDLE_SLOT)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(s_tvalid),
    .cmd_ready(s_tready),
    .cmd      (cmd),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output word register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {2'b00, out_q.error, out_q.switched, out_q.chosen_slot};

endmodule

>>> hw/rtl/tss_ram.sv
// Generic simple dual-port RAM with registered read.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/tss_engine.sv
// Slot table sequencer: slot RAM, write/wake/sleep updates and the two scans.
module tss_engine
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int IDLE_SLOT = IDLE_SLOT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

`include "timeslice_task_scheduler_macros.svh"

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  seq_state_t state, state_next;

  cmd_t               cmd_q;
  logic [CUR_W-1:0]   cur;
  logic [NUM_SLOTS-1:0] ent_init;
  logic               rd_init_q;
  logic [SLOT_W-1:0]  rd_addr_q;
  logic               p_vld;
  logic [CNT_W-1:0]   idx;
  logic [SLICE_W-1:0] best;
  logic [SLOT_W-1:0]  pick;
  logic               found;
  logic               err;

  logic               ren, wen;
  logic [SLOT_W-1:0]  raddr, waddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t             wdata;
  entry_t             ent;
  entry_t             ent_rst;

  logic               slot_ok, cur_ok, not_idle, last, issue;
  logic               cand1, cand2, found_now, wake_ok;
  logic [SLICE_W:0]   sum;
  logic [SLICE_W-1:0] sat;
  logic [CUR_W-1:0]   chosen;

  tss_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wen),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ren),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign slot_ok  = int'(cmd_q.slot) < NUM_SLOTS;
  assign cur_ok   = int'(cur) < NUM_SLOTS;
  assign not_idle = CUR_W'(rd_addr_q) != CUR_W'(IDLE_SLOT);

  // entries never written read as their reset value
  always_comb begin
    ent_rst           = '0;
    ent_rst.live      = !not_idle;
    ent               = rd_init_q ? entry_t'(rdata) : ent_rst;
  end

  assign last  = p_vld && (rd_addr_q == SLOT_W'(NUM_SLOTS - 1));
  assign issue = idx < CNT_W'(NUM_SLOTS);

  assign cand1 = p_vld && ent.live && (ent.run_state == RS_RUN) && (ent.slice > best);
  assign cand2 = p_vld && ent.live && not_idle && (ent.run_state == RS_RUN);
  assign found_now = found || cand1;
  assign wake_ok = slot_ok && ent.live &&
                   (ent.run_state == RS_INTR || ent.run_state == RS_UNINT);

  assign sum = {1'b0, ent.slice} + {1'b0, cfg.slice_inc};
  assign sat = (sum > {1'b0, cfg.slice_max}) ? cfg.slice_max : sum[SLICE_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.func)
            FN_SCHED: state_next = ST_SCAN1;
            FN_WRITE: state_next = ST_WRITE;
            FN_WAKE:  state_next = ST_RD_ONE;
            FN_SLEEP: state_next = cur_ok ? ST_RD_ONE : ST_SCAN1;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:  state_next = ST_RESP;
      ST_RD_ONE: state_next = (cmd_q.func == FN_WAKE) ? ST_WAKE : ST_SLEEP;
      ST_WAKE:   state_next = ST_RESP;
      ST_SLEEP:  state_next = ST_SCAN1;
      ST_SCAN1: begin
        if (last) begin
          state_next = found_now ? ST_RESP : ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ren   = 1'b0;
    raddr = idx[SLOT_W-1:0];
    wen   = 1'b0;
    waddr = rd_addr_q;
    wdata = ent;
    unique case (state)
      ST_WRITE: begin
        wen             = slot_ok;
        waddr           = SLOT_W'(cmd_q.slot);
        wdata.live      = cmd_q.valid_in;
        wdata.run_state = cmd_q.run_state_in;
        wdata.slice     = cmd_q.slice_in;
      end
      ST_RD_ONE: begin
        if (cmd_q.func == FN_WAKE) begin
          ren   = slot_ok;
          raddr = SLOT_W'(cmd_q.slot);
        end else begin
          ren   = 1'b1;
          raddr = SLOT_W'(cur);
        end
      end
      ST_WAKE: begin
        wen             = wake_ok;
        wdata.run_state = RS_RUN;
      end
      ST_SLEEP: begin
        wen             = 1'b1;
        wdata.run_state = cmd_q.interruptible ? RS_INTR : RS_UNINT;
      end
      ST_SCAN1: begin
        ren = issue;
      end
      ST_SCAN2: begin
        ren         = issue;
        wen         = p_vld && ent.live && not_idle;
        wdata.slice = sat;
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd_q.func == FN_SCHED || cmd_q.func == FN_SLEEP) begin
      chosen = found ? CUR_W'(pick) : CUR_W'(IDLE_SLOT);
    end else begin
      chosen = cur;
    end
    res.chosen_slot = chosen[SEL_W-1:0];
    res.switched    = chosen != cur;
    res.error       = err;
  end

  assign cmd_ready = (state == ST_IDLE) && !rst;
  assign res_valid = state == ST_RESP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= CUR_W'(IDLE_SLOT);
      ent_init <= '0;
      p_vld    <= 1'b0;
    end else begin
      state <= state_next;
      if (wen) begin
        ent_init[waddr] <= 1'b1;
      end
      if (state == ST_RESP && res_ready) begin
        cur <= chosen;
      end
      if (state != state_next &&
          (state_next == ST_SCAN1 || state_next == ST_SCAN2)) begin
        p_vld <= 1'b0;
      end else begin
        p_vld <= (state == ST_SCAN1 || state == ST_SCAN2) && issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rd_addr_q <= raddr;
      rd_init_q <= ent_init[raddr];
    end
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
      err   <= 1'b0;
    end
    if (state == ST_WAKE) begin
      err <= !wake_ok;
    end
    if (state != state_next &&
        (state_next == ST_SCAN1 || state_next == ST_SCAN2)) begin
      idx <= '0;
      if (state_next == ST_SCAN1) begin
        best  <= '0;
        found <= 1'b0;
      end
    end else if (state == ST_SCAN1 || state == ST_SCAN2) begin
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (state == ST_SCAN1 && cand1) begin
        best  <= ent.slice;
        pick  <= rd_addr_q;
        found <= 1'b1;
      end
      if (state == ST_SCAN2 && cand2) begin
        pick  <= rd_addr_q;
        found <= 1'b1;
      end
    end
  end

  // the refill pass reads one slot ahead of the one it writes back
  `TSS_ASSERT(a_rw_apart, (wen && ren) |-> (waddr != raddr), "read and write hit one entry")
  `TSS_ASSERT_NEVER(a_no_wr_scan1, state == ST_SCAN1 && wen, "write during first scan")
  `TSS_ASSERT(a_cur_legal, (int'(cur) < NUM_SLOTS) || (cur == CUR_W'(IDLE_SLOT)),
    "current slot outside table")
  `TSS_ASSERT(a_err_wake, (res_valid && res.error) |-> (cmd_q.func == FN_WAKE),
    "error flagged on non-wake")
  `TSS_ASSERT(a_sw_sched, (res_valid && res.switched) |->
    (cmd_q.func == FN_SCHED || cmd_q.func == FN_SLEEP), "switch on write or wake")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timeslice task scheduler: table-driven and random requests.
module tb_top;
  import tss_pkg::*;

  localparam int NSLOT          = NUM_SLOTS_DEF;
  localparam int IDLE           = IDLE_SLOT_DEF;
  localparam int DRAIN_CYCLES   = 2 * NSLOT + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP      = 20;
  localparam int DIR_ROWS       = 24;

  // run state that is neither runnable nor asleep
  localparam logic [RS_W-1:0] RS_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [3:0] slot, [4] valid_in, [6:5] run_state_in,
                                    // [14:7] slice_in, [15] interruptible
  logic [1:0]            s_tuser;   // [1:0] func
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] chosen_slot, [4] switched, [5] error, [7:6] zero
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SLICE_W-1:0]    cfg_data;

  timeslice_task_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scheduler state as the testbench sees it
  logic               tsk_live  [NSLOT];
  logic [RS_W-1:0]    tsk_state [NSLOT];
  logic [SLICE_W-1:0] tsk_slice [NSLOT];
  logic [SEL_W-1:0]   tsk_cur;
  logic [SLICE_W-1:0] slice_inc_now;
  logic [SLICE_W-1:0] slice_max_now;

  res_t pending_res [$];

  int send_idle_pct;
  int rcv_idle_pct;
  logic hold_req;
  int requests_sent;
  int results_seen;
  int mismatches;
  int settings_used;
  int stall_cycles;

  typedef struct packed {
    func_t              fn;
    logic [SEL_W-1:0]   slot;
    logic               live;
    logic [RS_W-1:0]    rs;
    logic [SLICE_W-1:0] slice;
    logic               intr;
    logic               fixed;
    logic [SEL_W-1:0]   w_slot;
    logic               w_sw;
    logic               w_err;
  } dir_row_t;

  // fixed = 1: expected word is typed in; otherwise it comes from the predictor
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b1, 4'd0,  1'b0, 1'b0},
    '{FN_WAKE,  4'd5,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b1, 4'd0,  1'b0, 1'b1},
    '{FN_WAKE,  4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b1, 4'd0,  1'b0, 1'b1},
    '{FN_WRITE, 4'd15, 1'b1, RS_RUN,    8'd255, 1'b0, 1'b1, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b1, 4'd15, 1'b1, 1'b0},
    '{FN_WRITE, 4'd3,  1'b1, RS_RUN,    8'd255, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd7,  1'b1, RS_UNUSED, 8'd200, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WAKE,  4'd7,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SLEEP, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SLEEP, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WAKE,  4'd3,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WAKE,  4'd15, 1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WAKE,  4'd15, 1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd0,  1'b1, RS_RUN,    8'd100, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd3,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd15, 1'b1, RS_INTR,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd9,  1'b1, RS_RUN,    8'd0,   1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_WRITE, 4'd12, 1'b1, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
    '{FN_SCHED, 4'd0,  1'b0, RS_RUN,    8'd0,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the state copy and returns the word it produces.
  function automatic res_t sched_predict(input cmd_t c);
    res_t             r;
    logic [SEL_W-1:0] nxt;
    logic [SLICE_W-1:0] best;
    bit               found;
    int unsigned      sum;
    r = '0;
    case (c.func)
      FN_WRITE: begin
        tsk_live[c.slot]  = c.valid_in;
        tsk_state[c.slot] = c.run_state_in;
        tsk_slice[c.slot] = c.slice_in;
      end
      FN_WAKE: begin
        if (tsk_live[c.slot] && (tsk_state[c.slot] == RS_INTR || tsk_state[c.slot] == RS_UNINT))
          tsk_state[c.slot] = RS_RUN;
        else
          r.error = 1'b1;
      end
      default: begin
        if (c.func == FN_SLEEP)
          tsk_state[tsk_cur] = c.interruptible ? RS_INTR : RS_UNINT;
        best  = '0;
        nxt   = SEL_W'(IDLE);
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
          if (tsk_live[i] && tsk_state[i] == RS_RUN && tsk_slice[i] > best) begin
            best  = tsk_slice[i];
            nxt   = SEL_W'(i);
            found = 1'b1;
          end
        end
        // refill pass: every live task but the idle one, last runnable wins
        if (!found) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (tsk_live[i] && i != IDLE) begin
              sum = 32'(tsk_slice[i]) + 32'(slice_inc_now);
              if (sum > 32'(slice_max_now)) sum = 32'(slice_max_now);
              tsk_slice[i] = sum[SLICE_W-1:0];
              if (tsk_state[i] == RS_RUN) begin
                nxt   = SEL_W'(i);
                found = 1'b1;
              end
            end
          end
        end
        if (!found) nxt = SEL_W'(IDLE);
        r.switched = (nxt != tsk_cur);
        tsk_cur = nxt;
      end
    endcase
    r.chosen_slot = tsk_cur;
    return r;
  endfunction

  // Random request, biased toward waking tasks that are actually asleep.
  function automatic cmd_t rand_request();
    cmd_t        c;
    int unsigned pick;
    int          asleep [$];
    c.slot          = SEL_W'($urandom_range(NSLOT - 1));
    c.valid_in      = ($urandom_range(9) != 0);
    c.interruptible = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 6)       c.run_state_in = RS_RUN;
    else if (pick == 6) c.run_state_in = RS_INTR;
    else if (pick == 7) c.run_state_in = RS_UNINT;
    else                c.run_state_in = RS_W'($urandom_range(3));
    pick = $urandom_range(9);
    if (pick == 0)      c.slice_in = '0;
    else if (pick == 1) c.slice_in = '1;
    else                c.slice_in = SLICE_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 30)      c.func = FN_WRITE;
    else if (pick < 60) c.func = FN_SCHED;
    else if (pick < 80) c.func = FN_SLEEP;
    else                c.func = FN_WAKE;
    if (c.func == FN_WAKE && $urandom_range(3) != 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (tsk_live[i] && (tsk_state[i] == RS_INTR || tsk_state[i] == RS_UNINT))
          asleep.push_back(i);
      if (asleep.size() != 0) c.slot = SEL_W'(asleep[$urandom_range(asleep.size() - 1)]);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH at %0t, result word %0d, %s: got %0d, expected %0d",
               $realtime, results_seen, what, got, want);
  endtask

  // Offers one word and records its expected result once it is taken.
  task automatic send_word(input cmd_t c, input bit fixed, input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.func;
    s_tdata  <= {c.interruptible, c.slice_in, c.run_state_in, c.valid_in, c.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = sched_predict(c);
    pending_res.push_back(fixed ? want : r);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SLICE_INC)      slice_inc_now = val;
    else if (idx == REG_SLICE_MAX) slice_max_now = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int snd_pct, input int rcv_pct,
                           input logic [SLICE_W-1:0] inc, input logic [SLICE_W-1:0] mx,
                           input bit with_hold);
    wait_drained();
    write_reg(REG_SLICE_INC, inc);
    write_reg(REG_SLICE_MAX, mx);
    settings_used++;
    send_idle_pct = snd_pct;
    rcv_idle_pct  = rcv_pct;
    for (int k = 0; k < n; k++) begin
      // long receiver stall while words keep coming, later a full drain
      if (with_hold && k == n / 3) hold_req <= 1'b1;
      if (k == 2 * n / 3) wait_drained();
      send_word(rand_request(), 1'b0, '0);
    end
  endtask

  // Receiver side
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_chk
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        report_mismatch("word with nothing pending", int'(m_tdata), 0);
      end else begin
        want = pending_res.pop_front();
        if (m_tdata[3:0] !== want.chosen_slot)
          report_mismatch("chosen_slot", int'(m_tdata[3:0]), int'(want.chosen_slot));
        if (m_tdata[4] !== want.switched)
          report_mismatch("switched", int'(m_tdata[4]), int'(want.switched));
        if (m_tdata[5] !== want.error)
          report_mismatch("error", int'(m_tdata[5]), int'(want.error));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results still pending",
               stall_cycles, pending_res.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    res_t fixed_res;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    requests_sent = 0;
    results_seen  = 0;
    mismatches    = 0;
    settings_used = 1;
    stall_cycles  = 0;
    for (int i = 0; i < NSLOT; i++) begin
      tsk_live[i]  = (i == IDLE);
      tsk_state[i] = RS_RUN;
      tsk_slice[i] = '0;
    end
    tsk_cur       = SEL_W'(IDLE);
    slice_inc_now = SLICE_INC_RST;
    slice_max_now = SLICE_MAX_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset register values
    send_idle_pct = 10;
    rcv_idle_pct  = 10;
    for (int k = 0; k < DIR_ROWS; k++) begin
      c.func          = dir_tab[k].fn;
      c.slot          = dir_tab[k].slot;
      c.valid_in      = dir_tab[k].live;
      c.run_state_in  = dir_tab[k].rs;
      c.slice_in      = dir_tab[k].slice;
      c.interruptible = dir_tab[k].intr;
      fixed_res.chosen_slot = dir_tab[k].w_slot;
      fixed_res.switched    = dir_tab[k].w_sw;
      fixed_res.error       = dir_tab[k].w_err;
      send_word(c, dir_tab[k].fixed, fixed_res);
    end

    run_phase(160, 23, 54, 8'd1, 8'd255, 1'b1);
    run_phase(160, 54, 23, 8'd255, 8'd1, 1'b0);
    run_phase(80, 0, 0, SLICE_W'($urandom_range(255, 1)), SLICE_W'($urandom_range(255, 1)),
              1'b0);
    run_phase(80, 0, 0, 8'd255, 8'd255, 1'b0);
    wait_drained();

    $display("Sent %0d requests (%0d from the directed table) under %0d register settings,",
             requests_sent, DIR_ROWS, settings_used);
    $display("with sender and receiver stalls and one long receiver hold; %0d words checked.",
             results_seen);
    if (mismatches == 0 && pending_res.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
